// ----- design/sha_pkg.sv -----
// Package for the SHA-256 stream hasher: payload structs, command codes,
// round constants, initial hash words and the round helper functions.
`timescale 1ns / 1ps
package sha_pkg;

	typedef enum logic [1:0] {
		CMD_ABSORB        = 2'd0,
		CMD_ABSORB_FINISH = 2'd1,
		CMD_FINISH        = 2'd2,
		CMD_UNUSED        = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Work request passed from the front to the back through the queue.
	typedef enum logic [1:0] {
		JOB_BYTE   = 2'd0,
		JOB_FINISH = 2'd1
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] data_byte;
	} job_t;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [8];
		h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return h[i];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- design/sha_front.sv -----
// Front end: accepts input requests, drops unused commands and turns the
// rest into byte and finish jobs for the queue. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front import sha_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);
	// A finish-with-byte request posts its byte, then split_q holds the front until the finish is posted.
	logic split_q;

	always_comb begin
		job.data_byte = in_data.data_byte;
		job.kind = JOB_BYTE;
		job_valid = 1'b0;
		in_ready = 1'b0;
		if (split_q) begin
			job.kind = JOB_FINISH;
			job_valid = 1'b1;
			in_ready = job_ready;
		end else begin
			case (cmd_t'(in_data.command))
				CMD_ABSORB, CMD_ABSORB_FINISH: begin
					job_valid = in_valid;
					in_ready = job_ready && (in_data.command == CMD_ABSORB);
				end
				CMD_FINISH: begin
					job.kind = JOB_FINISH;
					job_valid = in_valid;
					in_ready = job_ready;
				end
				default: in_ready = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 1'b0;
		end else if (split_q) begin
			if (job_ready) split_q <= 1'b0;
		end else if (in_valid && job_ready && in_data.command == CMD_ABSORB_FINISH) begin
			split_q <= 1'b1;
		end
	end
endmodule

// ----- design/sha_queue.sv -----
// Short job queue between the front and the back. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_queue import sha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_job,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_job
);
	job_t slot_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != QAW'(0) + (QAW+1)'(QDEPTH)) ? 1'b1 : 1'b0;
	assign rd_valid = (cnt_q != '0);
	assign rd_job = slot_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ----- design/sha_back.sv -----
// Back end: block store, length count, padding sequencer, one-round-per-cycle
// SHA-256 compression and digest output register. Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_back import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
	} state_t;

	state_t state_q;
	logic [31:0] chain_q [8];
	// The block store is held as sixteen big-endian words, one byte lane per write.
	logic [31:0] blk_q [16];
	logic [5:0] fill_q;
	logic [60:0] count_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [5:0] round_q;
	logic [5:0] pad_pos_q;
	logic finishing_q;  // padding in progress
	logic last_blk_q;   // compressing the block that holds the length
	logic [2:0] widx_q;
	logic [31:0] word_q;
	logic valid_q;

	// store write port
	logic st_we;
	logic [5:0] st_wa;
	logic [7:0] st_wd;
	logic [63:0] bit_len;

	logic [31:0] w_new, s0, s1, t1, t2, wt;

	assign bit_len = {count_q, 3'b000};
	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = valid_q;
	assign out_data.digest_word = word_q;
	assign out_data.word_index = widx_q;
	assign out_data.last_word = (widx_q == 3'd7);

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		wt = w_q[0];
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(round_q) + wt;
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Store write: absorbed bytes at fill_q; in padding, 0x80 first, zeros, length bytes in the tail.
	always_comb begin
		st_we = 1'b0;
		st_wa = fill_q;
		st_wd = job.data_byte;
		if (state_q == ST_IDLE && job_valid && job.kind == JOB_BYTE) begin
			st_we = 1'b1;
		end else if (state_q == ST_PAD) begin
			st_we = 1'b1;
			st_wa = pad_pos_q;
			if (pad_pos_q == fill_q && !last_blk_q) st_wd = PAD_BYTE;
			else if (pad_pos_q >= LEN_POS && last_blk_q)
				st_wd = bit_len[8*(7 - 32'(pad_pos_q[2:0])) +: 8];
			else st_wd = 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) blk_q[st_wa[5:2]][{~st_wa[1:0], 3'b000} +: 8] <= st_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
			fill_q <= '0;
			count_q <= '0;
			round_q <= '0;
			pad_pos_q <= '0;
			finishing_q <= 1'b0;
			last_blk_q <= 1'b0;
			widx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (job.kind == JOB_BYTE) begin
							fill_q <= fill_q + 1'b1;
							count_q <= count_q + 1'b1;
							if (fill_q == 6'd63) state_q <= ST_LOAD;
						end else begin
							finishing_q <= 1'b1;
							last_blk_q <= 1'b0;
							pad_pos_q <= fill_q;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// fill_q marks where the 0x80 goes; it is reset after the first pad block
					if (pad_pos_q == 6'd63) begin
						state_q <= ST_LOAD;
						if (!last_blk_q && fill_q < LEN_POS) last_blk_q <= 1'b1;
					end else if (pad_pos_q == fill_q - 1'b1 && fill_q < LEN_POS
					             && !last_blk_q && pad_pos_q == LEN_POS - 1'b1) begin
						pad_pos_q <= pad_pos_q + 1'b1;
					end else begin
						pad_pos_q <= pad_pos_q + 1'b1;
					end
					if (pad_pos_q == fill_q && !last_blk_q && fill_q < LEN_POS)
						last_blk_q <= 1'b1;
				end
				ST_LOAD: begin
					for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
					for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					round_q <= round_q + 1'b1;
					if (round_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
					fill_q <= '0;
					if (!finishing_q) begin
						state_q <= ST_IDLE;
					end else if (last_blk_q) begin
						widx_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						// Spill block done; the next block is zeros plus the length.
						last_blk_q <= 1'b1;
						pad_pos_q <= '0;
						state_q <= ST_PAD;
					end
				end
				ST_EMIT: begin
					if (!valid_q || out_ready) begin
						if (valid_q && widx_q == 3'd7) begin
							valid_q <= 1'b0;
							for (int i = 0; i < 8; i++) chain_q[i] <= init_h(3'(i));
							count_q <= '0;
							finishing_q <= 1'b0;
							last_blk_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							word_q <= chain_q[valid_q ? widx_q + 1'b1 : widx_q];
							if (valid_q) widx_q <= widx_q + 1'b1;
							valid_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- design/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: front end, job queue, back end.
// Depends on sha_pkg, sha_front, sha_queue and sha_back.
//
// Bytes arrive one request at a time; an absorb is taken while the job
// queue has room, and every 64th byte starts a compression of 64 rounds,
// one round per cycle in a single shared round unit, plus a load and a
// fold state. A finish walks the pad through the block store one byte a
// cycle, compresses one or two blocks and then presents the eight digest
// words on the output register, word 0 first. The queue of four jobs lets
// the source keep posting while a compression runs, until the queue is full.
`timescale 1ns / 1ps
module sha256_stream_hasher import sha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, b_job;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);
	sha_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_job(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job)
	);
	sha_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(b_valid), .job_ready(b_ready),
		.job(b_job), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// ----- design/sha_checker.sv -----
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_checker import sha_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
		else $error("last_word disagrees with word_index");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_word |=>
		out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
		else $error("digest words out of order");
endmodule

bind sha256_stream_hasher sha_checker u_checker (.*);
